// ===== src/pireg_pkg.sv =====
// Package for the PI PWM regulator: widths, constants, register indexes
// and the sequencer state type. No dependencies.
package pireg_pkg;

  localparam int SAMPLE_BITS = 14;
  localparam int DRIVE_BITS  = 12;

  localparam int Q16_W     = 18;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int INTEG_W   = 40;
  localparam int ILO_W     = INTEG_W / 2;
  localparam int FRAC_Q    = 24;

  localparam int FULL_SCALE_Q16 = 216269;
  localparam int STEP_Q16       = 655;
  localparam int SP_MIN         = 6554;
  localparam int SP_MAX         = 190054;
  localparam int SP_RESET       = 108134;

  localparam int PROP_RESET  = 6554;
  localparam int INTEG_RESET = 2560;
  localparam int UPPER_RESET = 2300;
  localparam int LOWER_RESET = 100;

  localparam int SPAN_W    = DRIVE_BITS + 1;
  localparam int NUM_W     = GAIN_W + DRIVE_BITS;
  localparam int DIV_W     = ((NUM_W + FRAC_Q + 1) / 2) * 2;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int P_W       = DIV_W + 1;
  localparam int I_W       = GAIN_W + INTEG_W + 1;
  localparam int DIFF_W    = I_W + 1;
  localparam int DRV_Q_W   = DIFF_W - FRAC_Q;
  localparam int ERR_W     = Q16_W + 2;

  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAS,
    S_PROP,
    S_INTEG,
    S_ILO,
    S_IHI,
    S_IACC,
    S_DIVW,
    S_FIN,
    S_OUT
  } state_t;

endpackage

// ===== src/pi_pwm_regulator_unit.sv =====
// PI PWM regulator top level: sequencer, state and result register.
// Depends on pireg_pkg, pireg_mul and pireg_div.
//
// in_ready is high only while the sequencer is idle, so a new item is taken
// only once the last one's result has been loaded into the output register.
// The proportional term comes from the serial divider, which forms
// prop_gain * span * 2^24 divided by the setpoint, two quotient bits a cycle
// over the 52 quotient bits. The converter scaling and the proportional
// product run on one registered multiplier ahead of the division, and the
// two partial products of the integral term share that multiplier while the
// division runs. The result waits in an output register, so a new item can
// be taken while it is still unclaimed; a result that finds that register
// still held stalls the sequencer until the held one is taken. After reset
// the setpoint is 1.65 V and the integral 0.
module pi_pwm_regulator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pireg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pireg_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pireg_pkg::SAMPLE_BITS-1:0]   adc_sample,
  input  logic                                raise_pressed,
  input  logic                                lower_pressed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pireg_pkg::DRIVE_BITS-1:0]    drive_count,
  output logic [pireg_pkg::Q16_W-1:0]         measured_q16,
  output logic [pireg_pkg::Q16_W-1:0]         setpoint_used
);
  import pireg_pkg::*;

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0]     prop_gain;
  logic [GAIN_W-1:0]     integral_gain;
  logic [DRIVE_BITS-1:0] drive_upper;
  logic [DRIVE_BITS-1:0] drive_lower;

  logic signed [INTEG_W-1:0] integral_sum;
  logic [Q16_W-1:0]          setpoint_q16;

  logic [SAMPLE_BITS-1:0] sample;
  logic                   raise;
  logic                   lower;
  logic [Q16_W-1:0]       used;
  logic [Q16_W-1:0]       measured;
  logic                   p_neg;
  logic signed [I_W-1:0]    i_acc;
  logic signed [DIFF_W-1:0] diff;
  logic [DRIVE_BITS-1:0]    drive;

  logic                      div_start;
  logic                      div_busy;
  logic [DIV_W-1:0]          quot;
  logic [NUM_W-1:0]          numer;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] prod_neg;
  logic                      out_load;

  logic signed [SPAN_W-1:0]  span;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   acc;
  logic signed [INTEG_W-1:0] acc_sat;
  logic signed [P_W-1:0]     p_val;
  logic signed [DIFF_W-1:0]  diff_adj;
  logic signed [DRV_Q_W-1:0] drv_q;
  logic signed [DRV_Q_W-1:0] drv_hi;
  logic signed [DRV_Q_W-1:0] drv_lo;
  logic signed [ERR_W-1:0]   sp_step;
  logic [Q16_W-1:0]          sp_next;

  pireg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pireg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (used),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_MEAS;
        end
      end
      S_MEAS:  state_next = S_PROP;
      S_PROP:  state_next = S_INTEG;
      S_INTEG: begin
        div_start  = 1'b1;
        state_next = S_ILO;
      end
      S_ILO:  state_next = S_IHI;
      S_IHI:  state_next = S_IACC;
      S_IACC: state_next = S_DIVW;
      S_DIVW: begin
        if (!div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    span = $signed({1'b0, drive_upper}) - $signed({1'b0, drive_lower});
    case (state)
      S_MEAS: begin
        mul_a = $signed(MUL_A_W'(sample));
        mul_b = $signed(MUL_B_W'(FULL_SCALE_Q16));
      end
      S_PROP: begin
        mul_a = MUL_A_W'(span);
        mul_b = $signed(MUL_B_W'(prop_gain));
      end
      S_ILO: begin
        mul_a = $signed(MUL_A_W'(integral_gain));
        mul_b = $signed(MUL_B_W'(integral_sum[ILO_W-1:0]));
      end
      default: begin
        mul_a = $signed(MUL_A_W'(integral_gain));
        mul_b = MUL_B_W'($signed(integral_sum[INTEG_W-1:ILO_W]));
      end
    endcase
  end

  always_comb begin
    prod_neg = -prod;
    numer    = prod[MUL_P_W-1] ? prod_neg[NUM_W-1:0] : prod[NUM_W-1:0];

    err = $signed(ERR_W'(used)) - $signed(ERR_W'(measured));
    acc = (INTEG_W + 1)'(integral_sum) + (INTEG_W + 1)'(err);
    if (acc[INTEG_W] != acc[INTEG_W-1]) begin
      acc_sat = acc[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                             : {1'b0, {(INTEG_W - 1){1'b1}}};
    end else begin
      acc_sat = acc[INTEG_W-1:0];
    end

    p_val = p_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    diff_adj = diff[DIFF_W-1] ? diff + DIFF_W'((64'd1 << FRAC_Q) - 64'd1) : diff;
    drv_q    = diff_adj[DIFF_W-1:FRAC_Q];
    drv_hi   = (drv_q > $signed(DRV_Q_W'(drive_upper))) ? $signed(DRV_Q_W'(drive_upper))
                                                         : drv_q;
    drv_lo   = (drv_hi < $signed(DRV_Q_W'(drive_lower))) ? $signed(DRV_Q_W'(drive_lower))
                                                          : drv_hi;

    sp_step = $signed(ERR_W'(used));
    if (raise) begin
      sp_step = sp_step + ERR_W'(STEP_Q16);
    end
    if (lower) begin
      sp_step = sp_step - ERR_W'(STEP_Q16);
    end
    if (sp_step < $signed(ERR_W'(SP_MIN))) begin
      sp_next = Q16_W'(SP_MIN);
    end else if (sp_step > $signed(ERR_W'(SP_MAX))) begin
      sp_next = Q16_W'(SP_MAX);
    end else begin
      sp_next = sp_step[Q16_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= GAIN_W'(PROP_RESET);
      integral_gain <= GAIN_W'(INTEG_RESET);
      drive_upper   <= DRIVE_BITS'(UPPER_RESET);
      drive_lower   <= DRIVE_BITS'(LOWER_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain     <= cfg_data;
        REG_INTEG_GAIN:  integral_gain <= cfg_data;
        REG_DRIVE_UPPER: drive_upper   <= cfg_data[DRIVE_BITS-1:0];
        REG_DRIVE_LOWER: drive_lower   <= cfg_data[DRIVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      setpoint_q16 <= Q16_W'(SP_RESET);
    end else begin
      if (state == S_INTEG) begin
        integral_sum <= acc_sat;
      end
      if (out_load) begin
        setpoint_q16 <= sp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sample <= adc_sample;
        raise  <= raise_pressed;
        lower  <= lower_pressed;
        used   <= setpoint_q16;
      end
      S_PROP:  measured <= prod[SAMPLE_BITS +: Q16_W];
      S_INTEG: p_neg <= prod[MUL_P_W-1];
      S_IHI:   i_acc <= I_W'(prod);
      S_IACC:  i_acc <= i_acc + (I_W'(prod) <<< ILO_W);
      S_DIVW:  diff <= DIFF_W'(p_val) - DIFF_W'(i_acc);
      S_FIN:   drive <= drv_lo[DRIVE_BITS-1:0];
      default: ;
    endcase
    if (out_load) begin
      drive_count   <= drive;
      measured_q16  <= measured;
      setpoint_used <= used;
    end
  end

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_busy)
    else $error("input ready while divider busy");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    setpoint_q16 >= Q16_W'(SP_MIN) && setpoint_q16 <= Q16_W'(SP_MAX))
    else $error("setpoint out of range");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    $fell(div_busy) |-> state == S_DIVW)
    else $error("divider finished outside wait state");

  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> !div_busy)
    else $error("drive formed before quotient ready");

endmodule

// ===== src/pireg_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pireg_pkg for operand widths.
module pireg_mul (
  input  logic                                  clk,
  input  logic signed [pireg_pkg::MUL_A_W-1:0]  a,
  input  logic signed [pireg_pkg::MUL_B_W-1:0]  b,
  output logic signed [pireg_pkg::MUL_P_W-1:0]  prod
);
  import pireg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ===== src/pireg_div.sv =====
// Serial restoring divider, two quotient bits per cycle; the dividend is
// the numerator shifted up by the Q24 fraction. Depends on pireg_pkg.
module pireg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pireg_pkg::NUM_W-1:0]   numer,
  input  logic [pireg_pkg::Q16_W-1:0]   denom,
  output logic                          busy,
  output logic [pireg_pkg::DIV_W-1:0]   quot
);
  import pireg_pkg::*;

  logic [Q16_W-1:0]     rem;
  logic [Q16_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;

  logic [Q16_W:0]   r_a;
  logic [Q16_W:0]   r_b;
  logic             ge_a;
  logic             ge_b;
  logic [Q16_W-1:0] rem_a;
  logic [Q16_W-1:0] rem_next;

  always_comb begin
    r_a      = {rem, quot[DIV_W-1]};
    ge_a     = r_a >= {1'b0, den};
    rem_a    = ge_a ? Q16_W'(r_a - {1'b0, den}) : r_a[Q16_W-1:0];
    r_b      = {rem_a, quot[DIV_W-2]};
    ge_b     = r_b >= {1'b0, den};
    rem_next = ge_b ? Q16_W'(r_b - {1'b0, den}) : r_b[Q16_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= DIV_W'(numer) << (DIV_W - NUM_W);
      rem  <= '0;
      den  <= denom;
    end else if (busy) begin
      quot <= {quot[DIV_W-3:0], ge_a, ge_b};
      rem  <= rem_next;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== verif/pi_pwm_regulator_unit_tb.sv =====
// Self-checking testbench for pi_pwm_regulator_unit: a directed table, then phases of random
// readings under different gain and drive-window settings, with random idling on both sides.
// Depends on pireg_pkg and the regulator RTL.
module pi_pwm_regulator_unit_tb;
  import pireg_pkg::*;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive;
    logic [Q16_W-1:0]      meas;
    logic [Q16_W-1:0]      sp;
  } reg_result_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   up;
    logic                   dn;
    logic                   typed;
    reg_result_t            want;
  } stim_row_t;

  typedef enum int {BIAS_MIXED, BIAS_RAISE, BIAS_LOWER} press_bias_t;

  localparam int     DIRECTED_ROWS = 20;
  localparam int     PHASES        = 10;
  localparam int     PHASE_ITEMS   = 135;
  localparam longint Q24_ONE       = 64'sd16777216;
  localparam longint INTEG_HI      = 64'sd549755813887;
  localparam longint INTEG_LO      = -INTEG_HI - 64'sd1;

  localparam reg_result_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{14'h0000, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h0000, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h0000, 1'b0, 1'b0, 1'b1,
      '{DRIVE_BITS'(LOWER_RESET), 18'd0, Q16_W'(SP_RESET)}},
    '{14'h3FFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{14'h3FFF, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{14'h3FFF, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{14'h1FFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h2000, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{14'h0001, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{14'h3FFE, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{14'h2AAA, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h1555, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{14'h3FFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h2000, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{14'h1FFF, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{14'h0F0F, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h30F0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{14'h1000, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{14'h0001, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{14'h3FFE, 1'b0, 1'b0, 1'b0, NO_RESULT}
  };

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_W-1:0]       cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic [SAMPLE_BITS-1:0] adc_sample    = '0;
  logic                   raise_pressed = 1'b0;
  logic                   lower_pressed = 1'b0;
  logic                   out_ready     = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [DRIVE_BITS-1:0]  drive_count;
  logic [Q16_W-1:0]       measured_q16;
  logic [Q16_W-1:0]       setpoint_used;

  logic [GAIN_W-1:0]      kp_cfg    = GAIN_W'(PROP_RESET);
  logic [GAIN_W-1:0]      ki_cfg    = GAIN_W'(INTEG_RESET);
  logic [DRIVE_BITS-1:0]  upper_cfg = DRIVE_BITS'(UPPER_RESET);
  logic [DRIVE_BITS-1:0]  lower_cfg = DRIVE_BITS'(LOWER_RESET);
  longint                 integ_acc = 0;
  int                     sp_state  = SP_RESET;

  reg_result_t pending_results [$];
  int          mismatch_count = 0;
  int          send_calm_left = 0;

  pi_pwm_regulator_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .adc_sample    (adc_sample),
    .raise_pressed (raise_pressed),
    .lower_pressed (lower_pressed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_count   (drive_count),
    .measured_q16  (measured_q16),
    .setpoint_used (setpoint_used)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

  function automatic reg_result_t regulate_step(input logic [SAMPLE_BITS-1:0] sample,
                                                input logic up, input logic dn);
    reg_result_t r;
    longint      meas;
    longint      acc;
    longint      span;
    longint      p_term;
    longint      i_term;
    longint      drv;
    longint      nxt;
    meas = (longint'(sample) * FULL_SCALE_Q16) >>> SAMPLE_BITS;
    acc  = integ_acc + (longint'(sp_state) - meas);
    if (acc > INTEG_HI) acc = INTEG_HI;
    if (acc < INTEG_LO) acc = INTEG_LO;
    integ_acc = acc;
    span   = longint'(upper_cfg) - longint'(lower_cfg);
    p_term = longint'(kp_cfg) * span * Q24_ONE / longint'(sp_state);
    i_term = longint'(ki_cfg) * integ_acc;
    drv    = (p_term - i_term) / Q24_ONE;
    if (drv > longint'(upper_cfg)) drv = longint'(upper_cfg);
    if (drv < longint'(lower_cfg)) drv = longint'(lower_cfg);
    r.drive = drv[DRIVE_BITS-1:0];
    r.meas  = meas[Q16_W-1:0];
    r.sp    = sp_state[Q16_W-1:0];
    nxt = sp_state;
    if (up) nxt += STEP_Q16;
    if (dn) nxt -= STEP_Q16;
    if (nxt < SP_MIN) nxt = SP_MIN;
    if (nxt > SP_MAX) nxt = SP_MAX;
    sp_state = int'(nxt);
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int roll;
    int nominal;
    roll = $urandom_range(0, 19);
    if (roll < 3) return roll[0] ? '1 : '0;
    if (roll < 11) return SAMPLE_BITS'($urandom);
    // track the setpoint, leaning so the integral is pulled back toward zero
    nominal = int'(longint'(sp_state) * (64'sd1 <<< SAMPLE_BITS) / FULL_SCALE_Q16);
    if (integ_acc > 0) nominal += $urandom_range(0, 40);
    else nominal -= $urandom_range(0, 40);
    return SAMPLE_BITS'(nominal);
  endfunction

  function automatic void pick_buttons(input press_bias_t bias, output logic up,
                                       output logic dn);
    int roll;
    roll = $urandom_range(0, 19);
    up   = 1'b0;
    dn   = 1'b0;
    case (bias)
      BIAS_RAISE: begin
        up = (roll < 17) || (roll == 18);
        dn = (roll >= 17) && (roll < 19);
      end
      BIAS_LOWER: begin
        dn = (roll < 17) || (roll == 18);
        up = (roll >= 17) && (roll < 19);
      end
      default: begin
        up = roll[0];
        dn = roll[1];
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    if (idx == REG_DRIVE_UPPER || idx == REG_DRIVE_LOWER) data[DRIVE_BITS-1:0] = DRIVE_BITS'(value);
    else data = CFG_W'(value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PROP_GAIN:   kp_cfg    = data[GAIN_W-1:0];
      REG_INTEG_GAIN:  ki_cfg    = data[GAIN_W-1:0];
      REG_DRIVE_UPPER: upper_cfg = data[DRIVE_BITS-1:0];
      default:         lower_cfg = data[DRIVE_BITS-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(input int kp, input int ki, input int up, input int lo);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DRIVE_UPPER, up);
    write_reg(REG_DRIVE_LOWER, lo);
    cfg_we <= 1'b0;
  endtask

  task automatic program_phase(input int ph, output press_bias_t bias);
    bias = BIAS_MIXED;
    case (ph)
      1: begin program_regs(65535, 65535, 4095, 0); bias = BIAS_RAISE; end
      2: begin program_regs(0, 0, 4095, 0); bias = BIAS_RAISE; end
      3: program_regs(PROP_RESET, INTEG_RESET, UPPER_RESET, LOWER_RESET);
      4: begin program_regs(65535, 0, 4095, 0); bias = BIAS_LOWER; end
      5: begin program_regs(0, 65535, 2000, 2000); bias = BIAS_LOWER; end
      6: begin program_regs(30000, 300, 500, 3000); bias = BIAS_LOWER; end
      7: begin
        program_regs($urandom_range(0, 65535), $urandom_range(0, 4000),
                     $urandom_range(2048, 4095), $urandom_range(0, 1024));
        bias = BIAS_RAISE;
      end
      8: program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
      default: program_regs($urandom_range(0, 65535), 1, 0, 4095);
    endcase
  endtask

  task automatic send_reading(input logic [SAMPLE_BITS-1:0] sample, input logic up,
                              input logic dn, input logic typed, input reg_result_t want);
    int          gap;
    reg_result_t pred;
    if (send_calm_left > 0) begin
      gap = 0;
      send_calm_left--;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 29) == 0) send_calm_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    adc_sample    <= sample;
    raise_pressed <= up;
    lower_pressed <= dn;
    do @(posedge clk); while (!in_ready);
    pred = regulate_step(sample, up, dn);
    pending_results.push_back(typed ? want : pred);
  endtask

  initial begin
    int          stall;
    int          calm_left;
    reg_result_t want;
    calm_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 3);
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("unexpected item: drive_count %0d, measured_q16 %0d, setpoint_used %0d",
               drive_count, measured_q16, setpoint_used);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (drive_count !== want.drive) begin
          $error("drive_count: expected %0d, got %0d", want.drive, drive_count);
          mismatch_count++;
        end
        if (measured_q16 !== want.meas) begin
          $error("measured_q16: expected %0d, got %0d", want.meas, measured_q16);
          mismatch_count++;
        end
        if (setpoint_used !== want.sp) begin
          $error("setpoint_used: expected %0d, got %0d", want.sp, setpoint_used);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    press_bias_t bias;
    logic        up;
    logic        dn;
    bias = BIAS_MIXED;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_reading(DIRECTED[i].sample, DIRECTED[i].up, DIRECTED[i].dn, DIRECTED[i].typed,
                   DIRECTED[i].want);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        program_phase(ph, bias);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_buttons(bias, up, dn);
        send_reading(pick_sample(), up, dn, 1'b0, NO_RESULT);
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== pi_pwm_regulator_unit.f =====
src/pireg_pkg.sv
src/pireg_mul.sv
src/pireg_div.sv
src/pi_pwm_regulator_unit.sv
verif/pi_pwm_regulator_unit_tb.sv
